// ----- hw/rtl/chm_pkg.sv -----
// shared types and constants of the compact hash map engine
`default_nettype none
package chm_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_DELETE
    } op_t;

    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ABSENT     = 2'd1;
    localparam logic [1:0] ST_SLOTS_FULL = 2'd2;
    localparam logic [1:0] ST_STORE_FULL = 2'd3;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_TOMB  = 2'd1;
    localparam logic [1:0] TAG_USED  = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [63:0] key;
        logic [63:0] hash;
        logic [63:0] value;
    } item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_KEY,
        S_EXEC,
        S_ALLOC,
        S_VAL
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/chm_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/chm_front.sv -----
// front end: accepts transactions, decodes the operation, two-entry queue
`default_nettype none
module chm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [191:0]   s_tdata,  // key, hash, value
    input  wire logic [1:0]     s_tuser,  // func
    output logic                item_valid,
    output chm_pkg::item_t      item,
    input  wire logic           item_pop
);

    chm_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    chm_pkg::item_t in_item;

    always_comb
    begin
        case (s_tuser)
            chm_pkg::FUNC_INSERT: in_item.op = chm_pkg::OP_INSERT;
            chm_pkg::FUNC_DELETE: in_item.op = chm_pkg::OP_DELETE;
            default:              in_item.op = chm_pkg::OP_LOOKUP;
        endcase
        in_item.key   = s_tdata[63:0];
        in_item.hash  = s_tdata[127:64];
        in_item.value = s_tdata[191:128];
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ item_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/chm_back.sv -----
// back end: probe sequencer, table memories and result register
`default_nettype none
module chm_back #(
    parameter int ENTRIES        = 64,
    parameter int INDEX_SLOTS    = 128,
    parameter int SHIFT_PER_STEP = 5,
    parameter int KEY_BITS       = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire chm_pkg::item_t item,
    output logic                item_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [71:0]         m_tdata,  // value_out, entry_index, zero pad
    output logic [1:0]          m_tuser   // status
);

    localparam int SL_W = $clog2(INDEX_SLOTS);
    localparam int ENT_W = $clog2(ENTRIES);
    localparam int SW_W = ENT_W + 2;
    localparam logic [SL_W-1:0] LAST_SLOT = SL_W'(INDEX_SLOTS - 1);
    localparam logic [ENT_W:0] ENT_CNT = (ENT_W + 1)'(ENTRIES);

    chm_pkg::state_t   state_reg, state_next;
    chm_pkg::op_t      op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [63:0]       val_reg, val_next;
    logic [63:0]       pert_reg, pert_next;
    logic [SL_W-1:0]   i_reg, i_next;
    logic [SL_W-1:0]   j_reg, j_next;
    logic              tomb_vld_reg, tomb_vld_next;
    logic [SL_W-1:0]   tomb_reg, tomb_next;
    logic              found_reg, found_next;
    logic              ins_vld_reg, ins_vld_next;
    logic [SL_W-1:0]   ins_reg, ins_next;
    logic [ENT_W-1:0]  d_reg, d_next;
    logic [ENT_W:0]    fc_reg, fc_next;
    logic [ENT_W:0]    uc_reg, uc_next;
    logic [SL_W-1:0]   clr_reg, clr_next;
    logic              ov_reg, ov_next;
    logic [1:0]        ost_reg, ost_next;
    logic [63:0]       oval_reg, oval_next;
    logic [ENT_W-1:0]  oidx_reg, oidx_next;

    logic              sl_we;
    logic [SL_W-1:0]   sl_waddr, sl_raddr;
    logic [SW_W-1:0]   sl_wdata, sl_rdata;
    logic              k_we;
    logic [ENT_W-1:0]  k_waddr, k_raddr;
    logic [KEY_BITS-1:0] k_rdata;
    logic              v_we;
    logic [ENT_W-1:0]  v_waddr, v_raddr;
    logic [63:0]       v_wdata, v_rdata;
    logic              f_we;
    logic [ENT_W-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;

    logic [63:0]       pert_step;
    logic [SL_W-1:0]   i_step;
    logic [ENT_W+5:0]  oidx_ext;

    chm_ram #(.WIDTH(SW_W), .DEPTH(INDEX_SLOTS)) u_slots (
        .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
        .raddr(sl_raddr), .rdata(sl_rdata)
    );
    chm_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_keys (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(key_reg),
        .raddr(k_raddr), .rdata(k_rdata)
    );
    chm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_vals (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );
    chm_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_free (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    assign pert_step = pert_reg >> SHIFT_PER_STEP;
    assign i_step    = i_reg + (i_reg << 2) + pert_step[SL_W-1:0] + SL_W'(1);
    assign oidx_ext  = {6'd0, oidx_reg};
    assign m_tvalid  = ov_reg;
    assign m_tuser   = ost_reg;
    assign m_tdata   = {2'b00, oidx_ext[5:0], oval_reg};

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        pert_next     = pert_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        tomb_vld_next = tomb_vld_reg;
        tomb_next     = tomb_reg;
        found_next    = found_reg;
        ins_vld_next  = ins_vld_reg;
        ins_next      = ins_reg;
        d_next        = d_reg;
        fc_next       = fc_reg;
        uc_next       = uc_reg;
        clr_next      = clr_reg;
        ov_next       = ov_reg && !m_tready;
        ost_next      = ost_reg;
        oval_next     = oval_reg;
        oidx_next     = oidx_reg;
        item_pop      = 1'b0;
        sl_we         = 1'b0;
        sl_waddr      = clr_reg;
        sl_wdata      = {chm_pkg::TAG_EMPTY, ENT_W'(0)};
        sl_raddr      = i_reg;
        k_we          = 1'b0;
        k_waddr       = d_reg;
        k_raddr       = sl_rdata[ENT_W-1:0];
        v_we          = 1'b0;
        v_waddr       = d_reg;
        v_wdata       = val_reg;
        v_raddr       = d_reg;
        f_we          = 1'b0;
        f_waddr       = fc_reg[ENT_W-1:0];
        f_wdata       = d_reg;
        f_raddr       = fc_reg[ENT_W-1:0] - ENT_W'(1);

        case (state_reg)
            chm_pkg::S_CLEAR:
            begin
                sl_we    = 1'b1;
                clr_next = clr_reg + SL_W'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = chm_pkg::S_IDLE;
                end
            end
            chm_pkg::S_IDLE:
            begin
                if (item_valid && !ov_reg)
                begin
                    item_pop      = 1'b1;
                    op_next       = item.op;
                    key_next      = item.key[KEY_BITS-1:0];
                    val_next      = item.value;
                    pert_next     = item.hash;
                    i_next        = item.hash[SL_W-1:0];
                    sl_raddr      = item.hash[SL_W-1:0];
                    j_next        = '0;
                    tomb_vld_next = 1'b0;
                    found_next    = 1'b0;
                    state_next    = chm_pkg::S_SLOT;
                end
            end
            chm_pkg::S_SLOT:
            begin
                d_next = sl_rdata[ENT_W-1:0];
                if (sl_rdata[SW_W-1:ENT_W] == chm_pkg::TAG_EMPTY)
                begin
                    ins_vld_next = 1'b1;
                    ins_next     = tomb_vld_reg ? tomb_reg : i_reg;
                    state_next   = chm_pkg::S_EXEC;
                end
                else if (sl_rdata[SW_W-1:ENT_W] == chm_pkg::TAG_USED)
                begin
                    state_next = chm_pkg::S_KEY;
                end
                else
                begin
                    if (!tomb_vld_reg)
                    begin
                        tomb_vld_next = 1'b1;
                        tomb_next     = i_reg;
                    end
                    if (j_reg == LAST_SLOT)
                    begin
                        ins_vld_next = 1'b1;
                        ins_next     = tomb_vld_reg ? tomb_reg : i_reg;
                        state_next   = chm_pkg::S_EXEC;
                    end
                    else
                    begin
                        pert_next = pert_step;
                        i_next    = i_step;
                        sl_raddr  = i_step;
                        j_next    = j_reg + SL_W'(1);
                    end
                end
            end
            chm_pkg::S_KEY:
            begin
                if (k_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = chm_pkg::S_EXEC;
                end
                else if (j_reg == LAST_SLOT)
                begin
                    ins_vld_next = tomb_vld_reg;
                    ins_next     = tomb_reg;
                    state_next   = chm_pkg::S_EXEC;
                end
                else
                begin
                    pert_next  = pert_step;
                    i_next     = i_step;
                    sl_raddr   = i_step;
                    j_next     = j_reg + SL_W'(1);
                    state_next = chm_pkg::S_SLOT;
                end
            end
            chm_pkg::S_EXEC:
            begin
                state_next = chm_pkg::S_IDLE;
                ov_next    = 1'b1;
                ost_next   = chm_pkg::ST_ABSENT;
                oval_next  = '0;
                oidx_next  = '0;
                case (op_reg)
                    chm_pkg::OP_INSERT:
                    begin
                        if (found_reg)
                        begin
                            v_we      = 1'b1;
                            ost_next  = chm_pkg::ST_OK;
                            oidx_next = d_reg;
                        end
                        else if (!ins_vld_reg)
                        begin
                            ost_next = chm_pkg::ST_SLOTS_FULL;
                        end
                        else if (fc_reg != '0)
                        begin
                            fc_next    = fc_reg - (ENT_W + 1)'(1);
                            ov_next    = ov_reg && !m_tready;
                            state_next = chm_pkg::S_ALLOC;
                        end
                        else if (uc_reg < ENT_CNT)
                        begin
                            sl_we     = 1'b1;
                            sl_waddr  = ins_reg;
                            sl_wdata  = {chm_pkg::TAG_USED, uc_reg[ENT_W-1:0]};
                            k_we      = 1'b1;
                            k_waddr   = uc_reg[ENT_W-1:0];
                            v_we      = 1'b1;
                            v_waddr   = uc_reg[ENT_W-1:0];
                            uc_next   = uc_reg + (ENT_W + 1)'(1);
                            ost_next  = chm_pkg::ST_OK;
                            oidx_next = uc_reg[ENT_W-1:0];
                        end
                        else
                        begin
                            ost_next = chm_pkg::ST_STORE_FULL;
                        end
                    end
                    chm_pkg::OP_DELETE:
                    begin
                        if (found_reg)
                        begin
                            sl_we    = 1'b1;
                            sl_waddr = i_reg;
                            sl_wdata = {chm_pkg::TAG_TOMB, ENT_W'(0)};
                            if (fc_reg < ENT_CNT)
                            begin
                                f_we    = 1'b1;
                                fc_next = fc_reg + (ENT_W + 1)'(1);
                            end
                            ost_next  = chm_pkg::ST_OK;
                            oidx_next = d_reg;
                        end
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            ov_next    = ov_reg && !m_tready;
                            state_next = chm_pkg::S_VAL;
                        end
                    end
                endcase
            end
            chm_pkg::S_ALLOC:
            begin
                sl_we      = 1'b1;
                sl_waddr   = ins_reg;
                sl_wdata   = {chm_pkg::TAG_USED, f_rdata};
                k_we       = 1'b1;
                k_waddr    = f_rdata;
                v_we       = 1'b1;
                v_waddr    = f_rdata;
                ov_next    = 1'b1;
                ost_next   = chm_pkg::ST_OK;
                oval_next  = '0;
                oidx_next  = f_rdata;
                state_next = chm_pkg::S_IDLE;
            end
            chm_pkg::S_VAL:
            begin
                ov_next    = 1'b1;
                ost_next   = chm_pkg::ST_OK;
                oval_next  = v_rdata;
                oidx_next  = d_reg;
                state_next = chm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = chm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::S_CLEAR;
            clr_reg   <= '0;
            fc_reg    <= '0;
            uc_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fc_reg    <= fc_next;
            uc_reg    <= uc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        pert_reg     <= pert_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        tomb_vld_reg <= tomb_vld_next;
        tomb_reg     <= tomb_next;
        found_reg    <= found_next;
        ins_vld_reg  <= ins_vld_next;
        ins_reg      <= ins_next;
        d_reg        <= d_next;
        ost_reg      <= ost_next;
        oval_reg     <= oval_next;
        oidx_reg     <= oidx_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/compact_hash_map_engine.sv -----
// top level of the compact hash map engine
// slave stream: one transaction per operation; tuser carries func (0 lookup,
//   1 insert or update, 2 delete, 3 acts as lookup), tdata carries key, hash
//   and value from the lowest bit up
// master stream: one transaction per operation; tuser carries the status,
//   tdata carries value_out and entry_index
// the probe visits one slot per cycle on an empty or tombstone slot; an occupied
//   slot takes a slot ram read, then a key ram read
// an operation passes from the queue through idle, the probe and the execute state
//   to a valid result: a lookup hit and an insert that reuses a freed position
//   add a ram read state (value ram or free list) before the result, and the
//   next operation starts in the cycle after the result is taken
// a two-entry queue sits between the decoder and the probe sequencer, so up to
//   two transactions are taken while a result waits in the output register
// after reset a clearing pass writes every slot empty, during which no
//   operation starts (the queue still fills)
// when the receiver stalls the result is held and the next operation waits
`default_nettype none
module compact_hash_map_engine #(
    parameter int ENTRIES        = 64,
    parameter int INDEX_SLOTS    = 128,
    parameter int SHIFT_PER_STEP = 5,
    parameter int KEY_BITS       = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,  // key, hash, value
    input  wire logic [1:0]   s_tuser,  // func
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata,  // value_out, entry_index, zero pad
    output logic [1:0]        m_tuser   // status
);

    chm_pkg::item_t item;
    logic           item_valid;
    logic           item_pop;

    chm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .item_valid(item_valid), .item(item), .item_pop(item_pop)
    );

    chm_back #(
        .ENTRIES(ENTRIES), .INDEX_SLOTS(INDEX_SLOTS),
        .SHIFT_PER_STEP(SHIFT_PER_STEP), .KEY_BITS(KEY_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item(item), .item_pop(item_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule
`default_nettype wire
